// ----- rtl/core/hrc_pkg.sv -----
// hrc_pkg: shared types and constants for the hash route cache
// transaction payloads, slot entry layout, controller command and status groups
// no dependencies
package hrc_pkg;

   localparam int SLOTS_DEF     = 256;
   localparam int MAX_PROBE_DEF = 4;

   localparam int OP_W    = 2;
   localparam int HASH_W  = 64;
   localparam int LEN_W   = 32;
   localparam int ROUTE_W = 8;
   localparam int STAMP_W = 64;
   localparam int CNT_W   = 32;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [HASH_W-1:0]  key_hash;
      logic [LEN_W-1:0]   query_length;
      logic [ROUTE_W-1:0] new_route;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [ROUTE_W-1:0] cached_route;
      logic               evicted;
      logic [CNT_W-1:0]   hit_count;
      logic [CNT_W-1:0]   miss_count;
      logic [CNT_W-1:0]   insert_count;
      logic [CNT_W-1:0]   eviction_count;
   } rsp_type;

   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [LEN_W-1:0]   length;
      logic [ROUTE_W-1:0] route;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic load_slot;
      logic probe_en;
      logic clear_en;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_flush;
      logic req_probe;
      logic home_done;
      logic decided;
      logic clear_done;
   } sts_type;

endpackage

// ----- rtl/core/hrc_ram.sv -----
// hrc_ram: generic single write port, single read port memory
// registered read data, no reset on the array
// no dependencies
module hrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/hrc_home.sv -----
// hrc_home: home slot index, key hash modulo slot count
// mask for a power-of-two slot count, else eight hash bits folded into the remainder per cycle
// depends on hrc_pkg
module hrc_home import hrc_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] key_hash,
   output logic              done,
   output logic [SLOT_W-1:0] home
);

   generate
      if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
         logic              done_ff;
         logic [SLOT_W-1:0] home_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else if (start) begin
               done_ff <= 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               home_ff <= key_hash[SLOT_W-1:0];
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_divide
         localparam int STEP     = 8;
         localparam int ROUNDS   = HASH_W / STEP;
         localparam int RND_W    = $clog2(ROUNDS + 1);

         logic [HASH_W-1:0] sh_ff;
         logic [HASH_W-1:0] sh_in;
         logic [SLOT_W-1:0] rem_ff;
         logic [SLOT_W-1:0] rem_in;
         logic [RND_W-1:0]  rnd_ff;
         logic [RND_W-1:0]  rnd_in;
         logic              busy_ff;
         logic              busy_in;
         logic              done_ff;
         logic              done_in;
         logic [SLOT_W-1:0] step_rem;

         always_comb begin
            logic [SLOT_W:0]   t;
            logic [SLOT_W-1:0] r;
            r = rem_ff;
            for (int i = 0; i < STEP; i++) begin
               t = {r, sh_ff[HASH_W-1-i]};
               if (t >= (SLOT_W+1)'(SLOTS)) begin
                  t = t - (SLOT_W+1)'(SLOTS);
               end
               r = t[SLOT_W-1:0];
            end
            step_rem = r;
         end

         always_comb begin
            sh_in   = sh_ff;
            rem_in  = rem_ff;
            rnd_in  = rnd_ff;
            busy_in = busy_ff;
            done_in = done_ff;
            if (start) begin
               sh_in   = key_hash;
               rem_in  = '0;
               rnd_in  = '0;
               busy_in = 1'b1;
               done_in = 1'b0;
            end else if (busy_ff) begin
               sh_in  = sh_ff << STEP;
               rem_in = step_rem;
               rnd_in = rnd_ff + 1'b1;
               if (rnd_ff == RND_W'(ROUNDS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               rnd_ff  <= '0;
            end else begin
               busy_ff <= busy_in;
               done_ff <= done_in;
               rnd_ff  <= rnd_in;
            end
         end

         always_ff @(posedge clock) begin
            sh_ff  <= sh_in;
            rem_ff <= rem_in;
         end

         assign done = done_ff;
         assign home = rem_ff;
      end
   endgenerate

endmodule

// ----- rtl/core/hrc_ctrl.sv -----
// hrc_ctrl: sequencing state machine of the hash route cache
// drives handshakes and datapath commands from datapath status
// depends on hrc_pkg
module hrc_ctrl import hrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_HASH   = 6'b000100,
      ST_PROBE  = 6'b001000,
      ST_FLUSH  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_flush) begin
                  state_in = ST_FLUSH;
               end else if (sts.req_probe) begin
                  state_in = ST_HASH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_HASH: begin
            if (sts.home_done) begin
               cmd.load_slot = 1'b1;
               state_in      = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.probe_en = 1'b1;
            if (sts.decided) begin
               state_in = ST_FINISH;
            end
         end
         ST_FLUSH: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/hrc_dpath.sv -----
// hrc_dpath: slot table, probe window, eviction choice, counters, result register
// depends on hrc_pkg, hrc_ram, hrc_home
module hrc_dpath import hrc_pkg::*; #(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_PROBE = MAX_PROBE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   output rsp_type rsp_data,
   input  cmd_type cmd,
   output sts_type sts
);

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int PW      = $clog2(MAX_PROBE + 1);
   localparam int ENTRY_W = $bits(entry_type);

   req_type            req_ff,       req_in;
   logic [SLOT_W-1:0]  slot_ff,      slot_in;
   logic [SLOT_W-1:0]  eval_slot_ff, eval_slot_in;
   logic [SLOT_W-1:0]  best_ff,      best_in;
   logic [SLOT_W-1:0]  clr_ff,       clr_in;
   logic [PW-1:0]      issue_ff,     issue_in;
   logic [PW-1:0]      eval_cnt_ff,  eval_cnt_in;
   logic               pend_ff,      pend_in;
   logic [STAMP_W-1:0] oldest_ff,    oldest_in;
   logic [STAMP_W-1:0] tick_ff,      tick_in;
   logic [CNT_W-1:0]   hits_ff,      hits_in;
   logic [CNT_W-1:0]   misses_ff,    misses_in;
   logic [CNT_W-1:0]   inserts_ff,   inserts_in;
   logic [CNT_W-1:0]   evicts_ff,    evicts_in;
   logic               hit_ff,       hit_in;
   logic [ROUTE_W-1:0] route_ff,     route_in;
   logic               evict_ff,     evict_in;
   rsp_type            rsp_ff,       rsp_in;

   logic               home_done;
   logic [SLOT_W-1:0]  home;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   entry_type          new_entry;
   logic [STAMP_W-1:0] tick_next;
   logic               issue;
   logic               eval;
   logic               is_lookup;
   logic               empty;
   logic               match;
   logic               last;
   logic               older;
   logic               decided;

   hrc_home #(
      .SLOTS(SLOTS)
   ) u_home (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.accept),
      .key_hash(req_data.key_hash),
      .done    (home_done),
      .home    (home)
   );

   hrc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(slot_ff),
      .rd_data(rd_data)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign tick_next = tick_ff + 1'b1;
   assign issue     = (issue_ff < PW'(MAX_PROBE));
   assign rd_en     = cmd.probe_en & issue;
   assign eval      = cmd.probe_en & pend_ff;
   assign is_lookup = (req_ff.opcode == OP_LOOKUP);
   assign empty     = (rd_entry.hash == '0);
   assign match     = (rd_entry.hash == req_ff.key_hash) &&
                      (rd_entry.length == req_ff.query_length);
   assign last      = (eval_cnt_ff == PW'(MAX_PROBE - 1));
   assign older     = (rd_entry.stamp < oldest_ff);

   always_comb begin
      new_entry.hash   = req_ff.key_hash;
      new_entry.length = req_ff.query_length;
      new_entry.route  = req_ff.new_route;
      new_entry.stamp  = tick_next;
   end

   // probe evaluation, table write and counter updates
   always_comb begin
      decided    = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = eval_slot_ff;
      wr_entry   = new_entry;
      oldest_in  = oldest_ff;
      best_in    = best_ff;
      tick_in    = tick_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      inserts_in = inserts_ff;
      evicts_in  = evicts_ff;
      hit_in     = hit_ff;
      route_in   = route_ff;
      evict_in   = evict_ff;
      clr_in     = clr_ff;

      if (cmd.clear_en) begin
         wr_en    = 1'b1;
         wr_addr  = clr_ff;
         wr_entry = '0;
         clr_in   = (clr_ff == SLOT_W'(SLOTS - 1)) ? '0 : clr_ff + 1'b1;
      end

      if (eval) begin
         if (is_lookup) begin
            if (empty) begin
               decided   = 1'b1;
               misses_in = misses_ff + 1'b1;
            end else if (match) begin
               decided        = 1'b1;
               hit_in         = 1'b1;
               route_in       = rd_entry.route;
               wr_en          = 1'b1;
               wr_entry       = rd_entry;
               wr_entry.stamp = tick_next;
               tick_in        = tick_next;
               hits_in        = hits_ff + 1'b1;
            end else if (last) begin
               decided   = 1'b1;
               misses_in = misses_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               decided    = 1'b1;
               wr_en      = 1'b1;
               tick_in    = tick_next;
               inserts_in = inserts_ff + 1'b1;
            end else if (match) begin
               decided        = 1'b1;
               wr_en          = 1'b1;
               wr_entry       = rd_entry;
               wr_entry.route = req_ff.new_route;
               wr_entry.stamp = tick_next;
               tick_in        = tick_next;
            end else if (last) begin
               decided    = 1'b1;
               wr_en      = 1'b1;
               wr_addr    = older ? eval_slot_ff : best_ff;
               tick_in    = tick_next;
               inserts_in = inserts_ff + 1'b1;
               evicts_in  = evicts_ff + 1'b1;
               evict_in   = 1'b1;
            end else if (older) begin
               oldest_in = rd_entry.stamp;
               best_in   = eval_slot_ff;
            end
         end
      end

      if (cmd.accept) begin
         hit_in   = 1'b0;
         route_in = '0;
         evict_in = 1'b0;
      end

      if (cmd.load_slot) begin
         oldest_in = '1;
         best_in   = home;
      end
   end

   // request capture, probe window walk with one read issued per cycle up to MAX_PROBE reads, result load
   always_comb begin
      req_in       = req_ff;
      slot_in      = slot_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      eval_slot_in = eval_slot_ff;
      eval_cnt_in  = eval_cnt_ff;
      rsp_in       = rsp_ff;

      if (cmd.accept) begin
         req_in = req_data;
      end

      if (cmd.load_slot) begin
         slot_in  = home;
         issue_in = '0;
         pend_in  = 1'b0;
      end else if (cmd.probe_en) begin
         pend_in      = issue & ~decided;
         eval_slot_in = slot_ff;
         eval_cnt_in  = issue_ff;
         if (issue) begin
            slot_in  = (slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : slot_ff + 1'b1;
            issue_in = issue_ff + 1'b1;
         end
      end

      if (cmd.load_rsp) begin
         rsp_in.hit            = hit_ff;
         rsp_in.cached_route   = route_ff;
         rsp_in.evicted        = evict_ff;
         rsp_in.hit_count      = hits_ff;
         rsp_in.miss_count     = misses_ff;
         rsp_in.insert_count   = inserts_ff;
         rsp_in.eviction_count = evicts_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         pend_ff    <= 1'b0;
         tick_ff    <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
         inserts_ff <= '0;
         evicts_ff  <= '0;
      end else begin
         clr_ff     <= clr_in;
         pend_ff    <= pend_in;
         tick_ff    <= tick_in;
         hits_ff    <= hits_in;
         misses_ff  <= misses_in;
         inserts_ff <= inserts_in;
         evicts_ff  <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      slot_ff      <= slot_in;
      eval_slot_ff <= eval_slot_in;
      best_ff      <= best_in;
      issue_ff     <= issue_in;
      eval_cnt_ff  <= eval_cnt_in;
      oldest_ff    <= oldest_in;
      hit_ff       <= hit_in;
      route_ff     <= route_in;
      evict_ff     <= evict_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      sts.req_flush  = (req_data.opcode == OP_FLUSH);
      sts.req_probe  = ((req_data.opcode == OP_LOOKUP) || (req_data.opcode == OP_INSERT)) &&
                       (req_data.query_length != '0);
      sts.home_done  = home_done;
      sts.decided    = decided;
      sts.clear_done = (clr_ff == SLOT_W'(SLOTS - 1));
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/hash_route_cache_linear_probe.sv -----
// hash_route_cache_linear_probe: key-to-route cache, linear probing, oldest-stamp eviction
// lookup or insert probing k slots (1..MAX_PROBE): home index, then one slot read per cycle
// from the home slot on, then result load; home index by serial division when SLOTS is not a
// power of two; one transaction at a time, a flush clearing every slot before its result;
// the next transaction is taken while a result waits in the output register
// synchronous reset: clearing sweep of all slots with req_stall high, counters and tick to zero
module hash_route_cache_linear_probe import hrc_pkg::*; #(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_PROBE = MAX_PROBE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   hrc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   hrc_dpath #(
      .SLOTS    (SLOTS),
      .MAX_PROBE(MAX_PROBE)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .rsp_data(rsp_data),
      .cmd     (cmd),
      .sts     (sts)
   );

endmodule
